>>> rtl/nkh_pkg.sv
// Package for the nucleotide k-mer histogram block.
// Field widths, character codes, the bin operation record and the sweep states.
// No dependencies.
package nkh_pkg;

   localparam int K_MAX_DEF = 6;

   localparam int SYM_W = 8;
   localparam int IDX_W = 12;
   localparam int CNT_W = 32;
   localparam int KLEN_W = 3;
   localparam logic [KLEN_W-1:0] KLEN_RESET = 3'd3;

   localparam logic [SYM_W-1:0] CH_A = 8'h41;
   localparam logic [SYM_W-1:0] CH_C = 8'h43;
   localparam logic [SYM_W-1:0] CH_G = 8'h47;
   localparam logic [SYM_W-1:0] CH_T = 8'h54;

   localparam logic [1:0] NT_A = 2'd0;
   localparam logic [1:0] NT_C = 2'd1;
   localparam logic [1:0] NT_G = 2'd2;
   localparam logic [1:0] NT_T = 2'd3;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_COUNT,
      OP_READ,
      OP_READ_CLEAR
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  addr;
   } bin_op_type;

   typedef enum logic {
      ST_CLEAR,
      ST_RUN
   } sweep_state_type;

endpackage

>>> rtl/nkh_chan_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on nkh_pkg for field widths.
interface nkh_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [nkh_pkg::SYM_W-1:0]    symbol;
   logic                         seq_end;
   logic [nkh_pkg::IDX_W-1:0]    bin_index;
   logic                         clear_after_read;

   modport source (output valid, kind, symbol, seq_end, bin_index, clear_after_read,
                   input ready);
   modport sink   (input valid, kind, symbol, seq_end, bin_index, clear_after_read,
                   output ready);
endinterface

interface nkh_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         counted;
   logic [nkh_pkg::IDX_W-1:0]    kmer_index;
   logic [nkh_pkg::CNT_W-1:0]    bin_count;
   logic [nkh_pkg::CNT_W-1:0]    total_count;

   modport source (output valid, counted, kmer_index, bin_count, total_count,
                   input ready);
   modport sink   (input valid, counted, kmer_index, bin_count, total_count,
                   output ready);
endinterface

>>> rtl/nkh_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// Read-first: a read and a write to the same address return the old data.
module nkh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/nkh_window.sv
// Front end: k-length register, character decode, rolling window and valid run.
// Produces the bin operation for the request on the channel. Depends on nkh_pkg.
module nkh_window #(
   parameter int K_MAX = nkh_pkg::K_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [nkh_pkg::KLEN_W-1:0] csr_wdata,
   input  logic                       accept,
   input  logic                       kind,
   input  logic [nkh_pkg::SYM_W-1:0]  symbol,
   input  logic                       seq_end,
   input  logic [nkh_pkg::IDX_W-1:0]  bin_index,
   input  logic                       clear_after_read,
   output nkh_pkg::bin_op_type        bin_op
);

   localparam int BIN_BITS = 2 * K_MAX;
   localparam int RUN_W = $clog2(K_MAX + 1);
   localparam int KC_W = (RUN_W > nkh_pkg::KLEN_W) ? RUN_W : nkh_pkg::KLEN_W;
   localparam int SH_W = $clog2(2 * (1 << KC_W) + 1);

   logic [nkh_pkg::KLEN_W-1:0] klen_ff;
   logic [BIN_BITS-1:0]        window_ff, window_in;
   logic [RUN_W-1:0]           run_ff, run_in;

   logic [KC_W-1:0]     klen_ext;
   logic [KC_W-1:0]     keff;
   logic [1:0]          code;
   logic                code_ok;
   logic [BIN_BITS-1:0] win_shift;
   logic [RUN_W-1:0]    run_next;
   logic [BIN_BITS-1:0] kmask;
   logic                count;

   always_comb begin
      klen_ext = KC_W'(klen_ff);
      if (klen_ext == '0) begin
         keff = KC_W'(1);
      end else if (klen_ext > KC_W'(K_MAX)) begin
         keff = KC_W'(K_MAX);
      end else begin
         keff = klen_ext;
      end

      code_ok = 1'b1;
      case (symbol)
         nkh_pkg::CH_A: code = nkh_pkg::NT_A;
         nkh_pkg::CH_C: code = nkh_pkg::NT_C;
         nkh_pkg::CH_G: code = nkh_pkg::NT_G;
         nkh_pkg::CH_T: code = nkh_pkg::NT_T;
         default: begin
            code = nkh_pkg::NT_A;
            code_ok = 1'b0;
         end
      endcase

      win_shift = BIN_BITS'({window_ff, code});
      run_next = (run_ff < RUN_W'(K_MAX)) ? RUN_W'(run_ff + 1'b1) : run_ff;
      kmask = ~({BIN_BITS{1'b1}} << (SH_W'(keff) << 1));
      count = code_ok && (KC_W'(run_next) >= keff);

      if (kind) begin
         bin_op.op = clear_after_read ? nkh_pkg::OP_READ_CLEAR : nkh_pkg::OP_READ;
         bin_op.addr = nkh_pkg::IDX_W'(bin_index[BIN_BITS-1:0]);
      end else if (count) begin
         bin_op.op = nkh_pkg::OP_COUNT;
         bin_op.addr = nkh_pkg::IDX_W'(win_shift & kmask);
      end else begin
         bin_op.op = nkh_pkg::OP_NONE;
         bin_op.addr = '0;
      end

      window_in = window_ff;
      run_in = run_ff;
      if (accept && !kind) begin
         if (!code_ok || seq_end) begin
            window_in = '0;
            run_in = '0;
         end else begin
            window_in = win_shift;
            run_in = run_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         klen_ff <= nkh_pkg::KLEN_RESET;
         window_ff <= '0;
         run_ff <= '0;
      end else begin
         if (csr_we) begin
            klen_ff <= csr_wdata;
         end
         window_ff <= window_in;
         run_ff <= run_in;
      end
   end

endmodule

>>> rtl/nkh_bin_update.sv
// Bin read-modify-write stage, running total, response register and the
// post-reset clearing sweep of the bin memory. Depends on nkh_pkg.
module nkh_bin_update #(
   parameter int K_MAX = nkh_pkg::K_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  nkh_pkg::bin_op_type        bin_op,
   output logic                       rd_en,
   output logic [2*K_MAX-1:0]         rd_addr,
   input  logic [nkh_pkg::CNT_W-1:0]  rd_data,
   output logic                       wr_en,
   output logic [2*K_MAX-1:0]         wr_addr,
   output logic [nkh_pkg::CNT_W-1:0]  wr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_counted,
   output logic [nkh_pkg::IDX_W-1:0]  rsp_kmer_index,
   output logic [nkh_pkg::CNT_W-1:0]  rsp_bin_count,
   output logic [nkh_pkg::CNT_W-1:0]  rsp_total_count
);

   localparam int BIN_BITS = 2 * K_MAX;
   localparam int CNT_W = nkh_pkg::CNT_W;

   nkh_pkg::sweep_state_type st_ff, st_in;
   logic [BIN_BITS-1:0]      clr_addr_ff, clr_addr_in;

   logic                     s1_valid_ff;
   nkh_pkg::bin_op_type      s1_op_ff;
   logic                     s1_hit_ff;
   logic [CNT_W-1:0]         s1_fwd_ff;
   logic [CNT_W-1:0]         total_ff, total_in;

   logic                     out_valid_ff;
   logic                     out_counted_ff;
   logic [nkh_pkg::IDX_W-1:0] out_kidx_ff;
   logic [CNT_W-1:0]         out_bin_ff;
   logic [CNT_W-1:0]         out_total_ff;

   logic                     accept;
   logic                     s1_adv;
   logic [CNT_W-1:0]         old_bin;
   logic                     bin_full;
   logic                     s1_wr;
   logic [CNT_W-1:0]         s1_wr_data;
   logic                     res_counted;
   logic [nkh_pkg::IDX_W-1:0] res_kidx;
   logic [CNT_W-1:0]         res_bin;
   logic [CNT_W-1:0]         res_total;

   // sweep sequencer
   always_comb begin
      st_in = st_ff;
      clr_addr_in = clr_addr_ff;
      case (st_ff)
         nkh_pkg::ST_CLEAR: begin
            clr_addr_in = BIN_BITS'(clr_addr_ff + 1'b1);
            if (clr_addr_ff == {BIN_BITS{1'b1}}) begin
               st_in = nkh_pkg::ST_RUN;
            end
         end
         nkh_pkg::ST_RUN: begin
            st_in = nkh_pkg::ST_RUN;
         end
         default: begin
            st_in = nkh_pkg::ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= nkh_pkg::ST_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         st_ff <= st_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign s1_adv = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = (st_ff == nkh_pkg::ST_RUN) && (!s1_valid_ff || s1_adv);
   assign accept = req_valid && req_ready;

   assign rd_en = accept;
   assign rd_addr = bin_op.addr[BIN_BITS-1:0];

   // write landing at the read edge is invisible to the read, so forward it
   assign old_bin = s1_hit_ff ? s1_fwd_ff : rd_data;
   assign bin_full = (old_bin == {CNT_W{1'b1}});

   always_comb begin
      s1_wr = 1'b0;
      s1_wr_data = '0;
      res_counted = 1'b0;
      res_kidx = '0;
      res_bin = '0;
      res_total = total_ff;
      total_in = total_ff;
      case (s1_op_ff.op)
         nkh_pkg::OP_COUNT: begin
            res_counted = 1'b1;
            res_kidx = s1_op_ff.addr;
            s1_wr = 1'b1;
            if (bin_full) begin
               s1_wr_data = old_bin;
            end else begin
               s1_wr_data = old_bin + 1'b1;
               if (total_ff != {CNT_W{1'b1}}) begin
                  total_in = total_ff + 1'b1;
               end
            end
            res_total = total_in;
         end
         nkh_pkg::OP_READ: begin
            res_bin = old_bin;
         end
         nkh_pkg::OP_READ_CLEAR: begin
            res_bin = old_bin;
            s1_wr = 1'b1;
            total_in = (total_ff >= old_bin) ? total_ff - old_bin : '0;
         end
         default: begin
            res_total = total_ff;
         end
      endcase
   end

   always_comb begin
      if (st_ff == nkh_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = s1_adv && s1_wr;
         wr_addr = s1_op_ff.addr[BIN_BITS-1:0];
         wr_data = s1_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
            total_ff <= total_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff <= bin_op;
         s1_hit_ff <= wr_en && (wr_addr == rd_addr);
         s1_fwd_ff <= wr_data;
      end
      if (s1_adv) begin
         out_counted_ff <= res_counted;
         out_kidx_ff <= res_kidx;
         out_bin_ff <= res_bin;
         out_total_ff <= res_total;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_counted = out_counted_ff;
   assign rsp_kmer_index = out_kidx_ff;
   assign rsp_bin_count = out_bin_ff;
   assign rsp_total_count = out_total_ff;

endmodule

>>> rtl/nucleotide_kmer_histogram.sv
// Top level of the nucleotide k-mer histogram.
// Depends on nkh_pkg, nkh_chan_if, nkh_ram, nkh_window and nkh_bin_update.
//
// Usage:
//   req_ch carries one item per transfer: a sequence character (kind 0) with
//   its seq_end mark, or a bin read (kind 1) with bin_index and
//   clear_after_read. rsp_ch returns exactly one result per item, in order.
//   csr_we/csr_wdata write the k-mer length; write it only while idle.
//   Throughput: one item per cycle while rsp_ch.ready is high. The bin
//   count is read from the bin RAM on the transfer edge, updated in the
//   update stage and written back as it advances, with the write that lands
//   on a read edge forwarded to that read, then registered for rsp_ch.
//   Reset: the window, run and total clear at once; req_ch.ready then stays
//   low while all 2^(2*K_MAX) bins (4096 at K_MAX = 6) are zeroed, one per
//   cycle. CSR writes are taken during that sweep.
//   Stall: one response register plus the update stage hold results; when
//   rsp_ch.ready is low and both are full, req_ch.ready drops.
module nucleotide_kmer_histogram #(
   parameter int K_MAX = nkh_pkg::K_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [nkh_pkg::KLEN_W-1:0] csr_wdata,
   nkh_req_if.sink                    req_ch,
   nkh_rsp_if.source                  rsp_ch
);

   localparam int BIN_BITS = 2 * K_MAX;

   nkh_pkg::bin_op_type          bin_op;
   logic                         rd_en;
   logic [BIN_BITS-1:0]          rd_addr;
   logic [nkh_pkg::CNT_W-1:0]    rd_data;
   logic                         wr_en;
   logic [BIN_BITS-1:0]          wr_addr;
   logic [nkh_pkg::CNT_W-1:0]    wr_data;
   logic                         accept;

   assign accept = req_ch.valid && req_ch.ready;

   nkh_window #(
      .K_MAX (K_MAX)
   ) u_window (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .accept           (accept),
      .kind             (req_ch.kind),
      .symbol           (req_ch.symbol),
      .seq_end          (req_ch.seq_end),
      .bin_index        (req_ch.bin_index),
      .clear_after_read (req_ch.clear_after_read),
      .bin_op           (bin_op)
   );

   nkh_ram #(
      .WIDTH (nkh_pkg::CNT_W),
      .DEPTH (1 << BIN_BITS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   nkh_bin_update #(
      .K_MAX (K_MAX)
   ) u_update (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .bin_op          (bin_op),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_counted     (rsp_ch.counted),
      .rsp_kmer_index  (rsp_ch.kmer_index),
      .rsp_bin_count   (rsp_ch.bin_count),
      .rsp_total_count (rsp_ch.total_count)
   );

endmodule

>>> rtl/nkh_checker.sv
// Port-level checks for nucleotide_kmer_histogram, bound to the top level.
// Depends on nkh_pkg for field widths.
module nkh_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_counted,
   input logic [nkh_pkg::CNT_W-1:0] rsp_total_count
);

   logic [1:0]                inflight_ff, inflight_in;
   logic                      prev_cnt_ff;
   logic [nkh_pkg::CNT_W-1:0] prev_total_ff;
   logic                      req_xfer;
   logic                      rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;
   assign inflight_in = 2'(inflight_ff + req_xfer - rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
         prev_cnt_ff <= 1'b0;
      end else begin
         inflight_ff <= inflight_in;
         if (rsp_xfer) begin
            prev_cnt_ff <= rsp_counted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_xfer) begin
         prev_total_ff <= rsp_total_count;
      end
   end

   // bin sweep holds off requests after reset
   a_sweep_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during bin sweep");

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (inflight_ff != 2'd0))
      else $error("response without an outstanding request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= 2'd2)
      else $error("more than two items in flight");

   // back-to-back counted characters never lower the total
   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_counted && prev_cnt_ff) |-> (rsp_total_count >= prev_total_ff))
      else $error("total fell between counted characters");

endmodule

bind nucleotide_kmer_histogram nkh_checker u_nkh_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_counted     (rsp_ch.counted),
   .rsp_total_count (rsp_ch.total_count)
);
